// ===== design/sps_pkg.sv =====
// Package for the servo pulse decoder: payload structs, register map codes,
// reset values, controller states and controller/datapath command types.
// No dependencies.
package sps_pkg;

	// Fixed field widths
	localparam int CAP_W      = 16;  // capture count on the request
	localparam int LEN_W      = 17;  // pulse length and pulse limits
	localparam int POS_W      = 12;  // position integer part
	localparam int PCT_W      = 7;   // change threshold in percent
	localparam int TMO_W      = 16;  // timeout and elapsed milliseconds
	localparam int SP_OUT_W   = 20;  // setpoint as shown on the response
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;
	localparam int PCT_SCALE  = 100;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF   = 8;

	// Request kinds
	localparam logic [1:0] REQ_TICK = 2'd0;
	localparam logic [1:0] REQ_EDGE = 2'd1;
	localparam logic [1:0] REQ_OVF  = 2'd2;

	// Register map
	localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_USB = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_POS_MIN    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_POS_MAX    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_PCT = 3'd6;

	// Register reset values
	localparam logic [LEN_W-1:0] RST_PULSE_MIN = 17'd24000;
	localparam logic [LEN_W-1:0] RST_PULSE_MAX = 17'd48000;
	localparam logic [TMO_W-1:0] RST_TIMEOUT   = 16'd100;
	localparam logic [POS_W-1:0] RST_POS_MIN   = 12'd0;
	localparam logic [POS_W-1:0] RST_POS_MAX   = 12'd4095;
	localparam logic [PCT_W-1:0] RST_PCT       = 7'd5;

	typedef struct packed {
		logic [1:0]       req_type;
		logic             pin_level;
		logic [CAP_W-1:0] capture_count;
		logic             usb_host;
	} sps_req_t;

	typedef struct packed {
		logic [SP_OUT_W-1:0] setpoint;
		logic                drive_enable;
		logic                present;
		logic                position_changed;
		logic                pulse_rejected;
	} sps_rsp_t;

	typedef struct packed {
		logic             ignore_when_usb;
		logic [LEN_W-1:0] pulse_min_counts;
		logic [LEN_W-1:0] pulse_max_counts;
		logic [TMO_W-1:0] timeout_ms;
		logic [POS_W-1:0] pos_min;
		logic [POS_W-1:0] pos_max;
		logic [PCT_W-1:0] change_pct;
	} sps_cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MUL,
		ST_LOAD,
		ST_DIV,
		ST_NEXT,
		ST_DIFF,
		ST_PROD,
		ST_DONE
	} sps_state_t;

	typedef struct packed {
		logic load_item;
		logic mul;
		logic load_div;
		logic div_step;
		logic calc_next;
		logic calc_diff;
		logic calc_prod;
		logic commit;
	} sps_cmd_t;

	typedef struct packed {
		logic map_needed;
	} sps_status_t;

endpackage

// ===== design/servo_pulse_to_setpoint.sv =====
// RC servo pulse decoder producing a position setpoint.
// Request channel (req_valid/req_ready/req_data) takes one event per
// transaction: a millisecond tick, a debounced pin edge with its capture
// count, or a timer overflow. Each request gives exactly one response on
// rsp_valid/rsp_ready/rsp_data with the setpoint (unsigned Q12.FRAC_BITS),
// drive enable, presence and the changed/rejected pulses.
// Configuration writes go through cfg_valid/cfg_ready/cfg_index/cfg_data,
// always ready; write only while no request is in flight.
// One request is processed at a time. Ticks, rising edges, overflows and
// rejected pulses go from evaluation straight to commit. An accepted
// falling edge also runs the multiply, the restoring divider that retires
// one quotient bit per cycle, and the next-setpoint, difference and
// threshold steps before commit. A new request is accepted only once the
// previous one has committed.
// A finished response sits in the output register; the next request is
// accepted meanwhile, and its result waits in the controller until the
// receiver takes the previous one. Reset (arst_n low) returns registers to
// their defaults, clears presence, drive enable, elapsed time and setpoint.
// Depends on sps_pkg, sps_cfg, sps_ctrl, sps_dp.
module servo_pulse_to_setpoint #(
	parameter int COUNT_WIDTH = sps_pkg::COUNT_WIDTH_DEF,
	parameter int FRAC_BITS   = sps_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  sps_pkg::sps_req_t               req_data,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output sps_pkg::sps_rsp_t               rsp_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sps_pkg::CFG_DATA_W-1:0]  cfg_data
);

	sps_pkg::sps_cfg_t    cfg;
	sps_pkg::sps_cmd_t    cmd;
	sps_pkg::sps_status_t status;

	sps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sps_ctrl #(
		.FRAC_BITS (FRAC_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.status    (status),
		.cmd       (cmd)
	);

	sps_dp #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_data (req_data),
		.cfg      (cfg),
		.cmd      (cmd),
		.status   (status),
		.rsp_data (rsp_data)
	);

endmodule

// ===== design/sps_cfg.sv =====
// Configuration register file for the servo pulse decoder.
// Depends on sps_pkg.
module sps_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sps_pkg::CFG_DATA_W-1:0]   cfg_data,
	output sps_pkg::sps_cfg_t                cfg
);

	sps_pkg::sps_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ignore_when_usb  <= 1'b0;
			cfg_q.pulse_min_counts <= sps_pkg::RST_PULSE_MIN;
			cfg_q.pulse_max_counts <= sps_pkg::RST_PULSE_MAX;
			cfg_q.timeout_ms       <= sps_pkg::RST_TIMEOUT;
			cfg_q.pos_min          <= sps_pkg::RST_POS_MIN;
			cfg_q.pos_max          <= sps_pkg::RST_POS_MAX;
			cfg_q.change_pct       <= sps_pkg::RST_PCT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sps_pkg::CFG_IGNORE_USB: cfg_q.ignore_when_usb  <= cfg_data[0];
				sps_pkg::CFG_PULSE_MIN:  cfg_q.pulse_min_counts <= cfg_data;
				sps_pkg::CFG_PULSE_MAX:  cfg_q.pulse_max_counts <= cfg_data;
				sps_pkg::CFG_TIMEOUT:    cfg_q.timeout_ms <= cfg_data[sps_pkg::TMO_W-1:0];
				sps_pkg::CFG_POS_MIN:    cfg_q.pos_min    <= cfg_data[sps_pkg::POS_W-1:0];
				sps_pkg::CFG_POS_MAX:    cfg_q.pos_max    <= cfg_data[sps_pkg::POS_W-1:0];
				sps_pkg::CFG_CHANGE_PCT: cfg_q.change_pct <= cfg_data[sps_pkg::PCT_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== design/sps_ctrl.sv =====
// Controller for the servo pulse decoder: sequences evaluation, multiply,
// serial divide, threshold check and commit; owns the handshakes.
// Depends on sps_pkg.
module sps_ctrl #(
	parameter int FRAC_BITS = sps_pkg::FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	input  sps_pkg::sps_status_t  status,
	output sps_pkg::sps_cmd_t     cmd
);

	localparam int DIV_STEPS = sps_pkg::POS_W + FRAC_BITS;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	sps_pkg::sps_state_t state_q, state_d;
	logic [CNT_W-1:0]    cnt_q;
	logic                rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sps_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			sps_pkg::ST_IDLE: begin
				if (req_valid) begin
					cmd.load_item = 1'b1;
					state_d       = sps_pkg::ST_EVAL;
				end
			end
			sps_pkg::ST_EVAL: begin
				state_d = status.map_needed ? sps_pkg::ST_MUL : sps_pkg::ST_DONE;
			end
			sps_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = sps_pkg::ST_LOAD;
			end
			sps_pkg::ST_LOAD: begin
				cmd.load_div = 1'b1;
				state_d      = sps_pkg::ST_DIV;
			end
			sps_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0) begin
					state_d = sps_pkg::ST_NEXT;
				end
			end
			sps_pkg::ST_NEXT: begin
				cmd.calc_next = 1'b1;
				state_d       = sps_pkg::ST_DIFF;
			end
			sps_pkg::ST_DIFF: begin
				cmd.calc_diff = 1'b1;
				state_d       = sps_pkg::ST_PROD;
			end
			sps_pkg::ST_PROD: begin
				cmd.calc_prod = 1'b1;
				state_d       = sps_pkg::ST_DONE;
			end
			sps_pkg::ST_DONE: begin
				// result register frees up when empty or being drained this cycle
				if (!rsp_valid_q || rsp_ready) begin
					cmd.commit = 1'b1;
					state_d    = sps_pkg::ST_IDLE;
				end
			end
			default: state_d = sps_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load_div) begin
			cnt_q <= CNT_W'(DIV_STEPS - 1);
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign req_ready = (state_q == sps_pkg::ST_IDLE);
	assign rsp_valid = rsp_valid_q;

endmodule

// ===== design/sps_dp.sv =====
// Datapath for the servo pulse decoder: request register, signal state,
// length-to-position multiply, restoring divider, change check, result register.
// Depends on sps_pkg.
module sps_dp #(
	parameter int COUNT_WIDTH = sps_pkg::COUNT_WIDTH_DEF,
	parameter int FRAC_BITS   = sps_pkg::FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sps_pkg::sps_req_t     req_data,
	input  sps_pkg::sps_cfg_t     cfg,
	input  sps_pkg::sps_cmd_t     cmd,
	output sps_pkg::sps_status_t  status,
	output sps_pkg::sps_rsp_t     rsp_data
);

	localparam int SW     = sps_pkg::POS_W + FRAC_BITS;     // setpoint width
	localparam int PW     = sps_pkg::POS_W + sps_pkg::LEN_W; // product width
	localparam int CW     = SW + sps_pkg::PCT_W;             // threshold compare width
	localparam int CAP_EF = (COUNT_WIDTH < sps_pkg::CAP_W) ? COUNT_WIDTH : sps_pkg::CAP_W;
	localparam logic [sps_pkg::CAP_W-1:0] CAP_MASK =
		sps_pkg::CAP_W'((64'd1 << CAP_EF) - 64'd1);

	sps_pkg::sps_req_t          item_q;
	sps_pkg::sps_rsp_t          rsp_q;
	logic                       present_q;
	logic                       running_q;
	logic [sps_pkg::TMO_W-1:0]  elapsed_q;
	logic [SW-1:0]              sp_q;
	logic [PW-1:0]              prod_q;
	logic [sps_pkg::LEN_W-1:0]  rem_q;
	logic [SW-1:0]              nsh_q;
	logic [SW-1:0]              quo_q;
	logic [SW-1:0]              next_q;
	logic [SW-1:0]              diff_q;
	logic [CW-1:0]              lhs_q;
	logic [CW-1:0]              rhs_q;

	logic                       ignored;
	logic                       in_range;
	logic [sps_pkg::LEN_W-1:0]  len;
	logic [sps_pkg::LEN_W-1:0]  off;
	logic [sps_pkg::LEN_W-1:0]  lspan;
	logic [sps_pkg::POS_W-1:0]  pspan;
	logic                       up;
	logic [SW-1:0]              base;
	logic [sps_pkg::LEN_W:0]    trial;
	logic                       trial_ge;

	// Pulse qualification
	assign ignored  = cfg.ignore_when_usb & item_q.usb_host;
	assign len      = sps_pkg::LEN_W'(item_q.capture_count & CAP_MASK) + 1'b1;
	assign in_range = (len <= cfg.pulse_max_counts) && (len >= cfg.pulse_min_counts);
	assign off      = len - cfg.pulse_min_counts;
	assign lspan    = cfg.pulse_max_counts - cfg.pulse_min_counts;
	assign up       = cfg.pos_max >= cfg.pos_min;
	assign pspan    = up ? (cfg.pos_max - cfg.pos_min) : (cfg.pos_min - cfg.pos_max);
	assign base     = SW'(cfg.pos_min) << FRAC_BITS;

	assign status.map_needed = (item_q.req_type == sps_pkg::REQ_EDGE) && !item_q.pin_level &&
		present_q && !ignored && in_range;

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= req_data;
		end
	end

	// Numerator is prod * 2^FRAC_BITS; quotient fits SW bits, so the remainder
	// starts from the numerator's bits above SW and SW bits are shifted in.
	assign trial    = {rem_q, nsh_q[SW-1]};
	assign trial_ge = trial >= {1'b0, lspan};

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= PW'(pspan) * PW'(off);
		end
		if (cmd.load_div) begin
			rem_q <= prod_q[PW-1:sps_pkg::POS_W];
			nsh_q <= SW'(prod_q[sps_pkg::POS_W-1:0]) << FRAC_BITS;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? sps_pkg::LEN_W'(trial - {1'b0, lspan})
			                  : trial[sps_pkg::LEN_W-1:0];
			nsh_q <= nsh_q << 1;
			quo_q <= {quo_q[SW-2:0], trial_ge};
		end
		if (cmd.calc_next) begin
			if (lspan == '0) begin
				next_q <= base;
			end else if (up) begin
				next_q <= base + quo_q;
			end else begin
				next_q <= base - quo_q;
			end
		end
		if (cmd.calc_diff) begin
			diff_q <= (next_q >= sp_q) ? (next_q - sp_q) : (sp_q - next_q);
		end
		if (cmd.calc_prod) begin
			lhs_q <= CW'(diff_q) * CW'(sps_pkg::PCT_SCALE);
			rhs_q <= (CW'(cfg.change_pct) * CW'(pspan)) << FRAC_BITS;
		end
	end

	// Next-state and result for the item being committed
	logic                      present_d;
	logic                      running_d;
	logic [sps_pkg::TMO_W-1:0] elapsed_d;
	logic [SW-1:0]             sp_d;
	logic                      changed;
	logic                      rejected;

	always_comb begin
		present_d = present_q;
		running_d = running_q;
		elapsed_d = elapsed_q;
		sp_d      = sp_q;
		changed   = 1'b0;
		rejected  = 1'b0;
		case (item_q.req_type)
			sps_pkg::REQ_TICK: begin
				if (present_q) begin
					if (elapsed_q >= cfg.timeout_ms) begin
						present_d = 1'b0;
						if (!ignored) begin
							running_d = 1'b0;
							sp_d      = '0;
						end
					end else begin
						elapsed_d = elapsed_q + 1'b1;
					end
				end
			end
			sps_pkg::REQ_EDGE: begin
				if (item_q.pin_level) begin
					present_d = 1'b1;
					elapsed_d = '0;
				end else if (present_q && !ignored) begin
					if (in_range) begin
						sp_d      = next_q;
						running_d = 1'b1;
						changed   = (pspan == '0) ? (diff_q != '0) : (lhs_q >= rhs_q);
					end else begin
						present_d = 1'b0;
						running_d = 1'b0;
						rejected  = 1'b1;
					end
				end
			end
			sps_pkg::REQ_OVF: present_d = 1'b0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= 1'b0;
			running_q <= 1'b0;
			elapsed_q <= '0;
			sp_q      <= '0;
		end else if (cmd.commit) begin
			present_q <= present_d;
			running_q <= running_d;
			elapsed_q <= elapsed_d;
			sp_q      <= sp_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q.setpoint         <= sps_pkg::SP_OUT_W'(sp_d);
			rsp_q.drive_enable     <= running_d;
			rsp_q.present          <= present_d;
			rsp_q.position_changed <= changed;
			rsp_q.pulse_rejected   <= rejected;
		end
	end

	assign rsp_data = rsp_q;

endmodule

// ===== design/sps_checker.sv =====
// Port-level checks for servo_pulse_to_setpoint, bound to the top level.
// Depends on sps_pkg.
module sps_port_props (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            req_valid,
	input logic                            req_ready,
	input logic                            rsp_valid,
	input logic                            rsp_ready,
	input sps_pkg::sps_rsp_t               rsp_data
);

	// A stalled response keeps its transaction
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response changed while stalled");

	// One request in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in flight");

	// A rejected pulse drops presence and the drive
	a_reject_drops: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.pulse_rejected |->
			!rsp_data.present && !rsp_data.drive_enable && !rsp_data.position_changed)
		else $error("rejected pulse left signal or drive active");

	// A position change only comes with an accepted pulse
	a_change_runs: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.position_changed |->
			rsp_data.present && rsp_data.drive_enable)
		else $error("position change without running drive");

endmodule

bind servo_pulse_to_setpoint sps_port_props u_sps_port_props (.*);
